// ===== src/quadrature_detent_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Quadrature detent decoder assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_DETENT_DECODER_ASSERT_SVH
`define QUADRATURE_DETENT_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QDD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/qdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadrature detent decoder package
// Types, codes and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package qdd_pkg;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned PINS_W      = 2;
  localparam int unsigned LOAD_W      = 16;
  localparam int unsigned TOTAL_W     = 16;

  // Pin levels: wiper A in bit 1, wiper B in bit 0.
  localparam logic [PINS_W-1:0] PINS_HL = 2'b10;
  localparam logic [PINS_W-1:0] PINS_LH = 2'b01;
  localparam logic [PINS_W-1:0] PINS_HH = 2'b11;
  localparam logic [PINS_W-1:0] PINS_LL = 2'b00;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SAMPLE     = 3'd0,
    OP_READ_CLEAR = 3'd1,
    OP_LOAD_CW    = 3'd2,
    OP_LOAD_CCW   = 3'd3,
    OP_SYNC       = 3'd4
  } opcode_e;

  typedef enum logic [3:0] {
    PH_HH = 4'b0001,
    PH_HL = 4'b0010,
    PH_LL = 4'b0100,
    PH_LH = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    DIR_STILL = 2'd0,
    DIR_CW    = 2'd1,
    DIR_CCW   = 2'd2
  } dir_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [PINS_W-1:0]   pins;
    logic [LOAD_W-1:0]   load_value;
  } qdd_req_t;

  typedef struct packed {
    logic [1:0]         direction_seen;
    logic [TOTAL_W-1:0] cw_total;
    logic [TOTAL_W-1:0] ccw_total;
  } qdd_rsp_t;

  typedef struct packed {
    phase_e                 now;
    phase_e                 prev;
    dir_e                   dir;
    logic [COUNT_WIDTH-1:0] cw;
    logic [COUNT_WIDTH-1:0] ccw;
  } qdd_state_t;

  localparam qdd_state_t STATE_RESET = '{
    now:  PH_HH,
    prev: PH_HH,
    dir:  DIR_STILL,
    cw:   '0,
    ccw:  '0
  };

  function automatic phase_e phase_of_pins(input logic [PINS_W-1:0] pins);
    phase_e ph;
    case (pins)
      PINS_LL: ph = PH_LL;
      PINS_LH: ph = PH_LH;
      PINS_HL: ph = PH_HL;
      default: ph = PH_HH;
    endcase
    return ph;
  endfunction

endpackage

`default_nettype wire

// ===== src/quadrature_detent_decoder.sv =====
// ----------------------------------------------------------------------------
// Quadrature detent decoder
// Counts clockwise and counterclockwise detents of a two-wiper encoder.
// ----------------------------------------------------------------------------
// One request enters per clock unless the input stalls: the request is captured
// in an input register, the step logic updates the phase machine, direction
// latch and counters, and the result is held in an output register until it is
// taken. Throughput is one request per cycle while the output is not stalled,
// set by the feedback from the state registers through the step logic. The
// input stalls only when both registers are full and the output is stalled.
`default_nettype none

module quadrature_detent_decoder import qdd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire qdd_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output qdd_rsp_t      out_rsp_o
);

  logic       in_valid_q, in_valid_d;
  qdd_req_t   in_req_q;
  logic       res_valid_q, res_valid_d;
  qdd_rsp_t   res_rsp_q;
  qdd_state_t state_q, state_d;
  qdd_rsp_t   step_rsp;
  logic       res_ready;
  logic       fire;
  logic       in_accept;

  assign res_ready  = !res_valid_q || !out_stall_i;
  assign fire       = in_valid_q && res_ready;
  assign in_stall_o = in_valid_q && !res_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  qdd_step u_step (
    .state_i (state_q),
    .req_i   (in_req_q),
    .state_o (state_d),
    .rsp_o   (step_rsp)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (res_ready) begin
      res_valid_d = fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_req_q <= in_req_i;
    end
    if (fire) begin
      res_rsp_q <= step_rsp;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_rsp_o   = res_rsp_q;

`include "quadrature_detent_decoder_assert.svh"

  `QDD_ASSERT_NEXT(a_req_held, in_valid_q && !fire, in_valid_q, "queued request was dropped")
  `QDD_ASSERT_NEXT(a_cw_step, fire && in_req_q.opcode == OP_SAMPLE, state_q.cw == $past(state_q.cw) || state_q.cw == $past(state_q.cw) + 1'b1, "cw counter jumped on a sample")
  `QDD_ASSERT_NEXT(a_one_dir, fire && in_req_q.opcode == OP_SAMPLE, state_q.cw == $past(state_q.cw) || state_q.ccw == $past(state_q.ccw), "both counters moved on one sample")
  `QDD_ASSERT_NEXT(a_dir_clear, fire && in_req_q.opcode == OP_READ_CLEAR, state_q.dir == DIR_STILL, "direction not cleared by read")

endmodule

`default_nettype wire

// ===== src/qdd_step.sv =====
// ----------------------------------------------------------------------------
// Quadrature detent decoder step logic
// Works out the next decoder state and the result for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module qdd_step import qdd_pkg::*; (
  input  wire qdd_state_t state_i,
  input  wire qdd_req_t   req_i,
  output qdd_state_t      state_o,
  output qdd_rsp_t        rsp_o
);

  qdd_state_t nxt;
  dir_e       seen;

  always_comb begin
    nxt = state_i;
    case (req_i.opcode)
      OP_SAMPLE: begin
        case (state_i.now)
          PH_HH: begin
            if (req_i.pins == PINS_HL) begin
              nxt.prev = state_i.now;
              nxt.now  = PH_HL;
            end else if (req_i.pins == PINS_LH) begin
              nxt.prev = state_i.now;
              nxt.now  = PH_LH;
            end
          end
          PH_HL: begin
            if (req_i.pins == PINS_HH) begin
              nxt.prev = state_i.now;
              nxt.now  = PH_HH;
            end else if (req_i.pins == PINS_LL && state_i.prev == PH_HH) begin
              nxt.prev = state_i.now;
              nxt.now  = PH_LL;
              nxt.dir  = DIR_CW;
              nxt.cw   = state_i.cw + 1'b1;
            end
          end
          PH_LH: begin
            if (req_i.pins == PINS_HH) begin
              nxt.prev = state_i.now;
              nxt.now  = PH_HH;
            end else if (req_i.pins == PINS_LL && state_i.prev == PH_HH) begin
              nxt.prev = state_i.now;
              nxt.now  = PH_LL;
              nxt.dir  = DIR_CCW;
              nxt.ccw  = state_i.ccw + 1'b1;
            end
          end
          default: begin
            // Both wipers low: only a step onward through the detent, away from the previous phase, moves on.
            if (req_i.pins == PINS_LH && state_i.prev == PH_HL) begin
              nxt.prev = state_i.now;
              nxt.now  = PH_LH;
            end else if (req_i.pins == PINS_HL && state_i.prev == PH_LH) begin
              nxt.prev = state_i.now;
              nxt.now  = PH_HL;
            end
          end
        endcase
      end
      OP_LOAD_CW:  nxt.cw  = COUNT_WIDTH'(req_i.load_value);
      OP_LOAD_CCW: nxt.ccw = COUNT_WIDTH'(req_i.load_value);
      OP_SYNC:     nxt.now = phase_of_pins(req_i.pins);
      default: ;
    endcase

    // The read reports the direction held before it clears it.
    seen = nxt.dir;
    if (req_i.opcode == OP_READ_CLEAR) begin
      nxt.dir = DIR_STILL;
    end
  end

  assign state_o              = nxt;
  assign rsp_o.direction_seen = seen;
  assign rsp_o.cw_total       = TOTAL_W'(nxt.cw);
  assign rsp_o.ccw_total      = TOTAL_W'(nxt.ccw);

endmodule

`default_nettype wire

// ===== bench/quadrature_detent_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quadrature detent decoder testbench
// Drives short directed and long random request streams into the decoder.
// Every accepted request goes to a scoreboard. The scoreboard steps its own
// copy of the phase machine, direction latch and counters, and checks each
// returned result field by field against the oldest expected one. Both
// sides idle at random. There is one long receiver hold-off and one
// pause until all results have drained.
// ----------------------------------------------------------------------------

module quadrature_detent_decoder_tb;
  import qdd_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
  localparam logic [LOAD_W-1:0]   LOAD_MAX    = '1;
  localparam int unsigned TOTAL_REQUESTS  = 1850;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned REPORT_LIMIT    = 200;

  class detent_scoreboard;
    phase_e                 ph_now;
    phase_e                 ph_prev;
    dir_e                   dir_latch;
    logic [COUNT_WIDTH-1:0] cw_cnt;
    logic [COUNT_WIDTH-1:0] ccw_cnt;
    qdd_rsp_t               expected_totals_q[$];
    int unsigned            mismatches;

    function new();
      ph_now     = PH_HH;
      ph_prev    = PH_HH;
      dir_latch  = DIR_STILL;
      cw_cnt     = '0;
      ccw_cnt    = '0;
      mismatches = 0;
    endfunction

    // Steps the predicted decoder state by one accepted request and queues
    // the result it should produce.
    function void predict_detents(input qdd_req_t req);
      qdd_rsp_t want;
      case (req.opcode)
        OP_SAMPLE: begin
          case (ph_now)
            PH_HH: begin
              if (req.pins == PINS_HL) begin
                ph_prev = ph_now;
                ph_now  = PH_HL;
              end else if (req.pins == PINS_LH) begin
                ph_prev = ph_now;
                ph_now  = PH_LH;
              end
            end
            PH_HL: begin
              if (req.pins == PINS_HH) begin
                ph_prev = ph_now;
                ph_now  = PH_HH;
              end else if (req.pins == PINS_LL && ph_prev == PH_HH) begin
                ph_prev   = ph_now;
                ph_now    = PH_LL;
                dir_latch = DIR_CW;
                cw_cnt    = cw_cnt + 1'b1;
              end
            end
            PH_LH: begin
              if (req.pins == PINS_HH) begin
                ph_prev = ph_now;
                ph_now  = PH_HH;
              end else if (req.pins == PINS_LL && ph_prev == PH_HH) begin
                ph_prev   = ph_now;
                ph_now    = PH_LL;
                dir_latch = DIR_CCW;
                ccw_cnt   = ccw_cnt + 1'b1;
              end
            end
            default: begin
              if (req.pins == PINS_LH && ph_prev == PH_HL) begin
                ph_prev = ph_now;
                ph_now  = PH_LH;
              end else if (req.pins == PINS_HL && ph_prev == PH_LH) begin
                ph_prev = ph_now;
                ph_now  = PH_HL;
              end
            end
          endcase
        end
        OP_LOAD_CW:  cw_cnt  = req.load_value[COUNT_WIDTH-1:0];
        OP_LOAD_CCW: ccw_cnt = req.load_value[COUNT_WIDTH-1:0];
        OP_SYNC: begin
          // Sync forces the current phase only; the previous one is kept.
          case (req.pins)
            PINS_LL: ph_now = PH_LL;
            PINS_LH: ph_now = PH_LH;
            PINS_HL: ph_now = PH_HL;
            default: ph_now = PH_HH;
          endcase
        end
        default: ;
      endcase
      want.direction_seen = dir_latch;
      want.cw_total       = cw_cnt[TOTAL_W-1:0];
      want.ccw_total      = ccw_cnt[TOTAL_W-1:0];
      if (req.opcode == OP_READ_CLEAR) dir_latch = DIR_STILL;
      expected_totals_q.push_back(want);
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      // Keeps the log readable if the block goes badly wrong.
      if (mismatches <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_totals(input qdd_rsp_t got);
      qdd_rsp_t want;
      if (expected_totals_q.size() == 0) begin
        report_mismatch("result returned with no request outstanding");
        return;
      end
      want = expected_totals_q.pop_front();
      if (got.direction_seen !== want.direction_seen)
        report_mismatch($sformatf("direction_seen got %0d expected %0d",
                                  got.direction_seen, want.direction_seen));
      if (got.cw_total !== want.cw_total)
        report_mismatch($sformatf("cw_total got %0h expected %0h",
                                  got.cw_total, want.cw_total));
      if (got.ccw_total !== want.ccw_total)
        report_mismatch($sformatf("ccw_total got %0h expected %0h",
                                  got.ccw_total, want.ccw_total));
    endtask

    function int unsigned outstanding();
      return expected_totals_q.size();
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  qdd_req_t in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  qdd_rsp_t out_rsp_o;

  detent_scoreboard tally = new();
  int unsigned requests_sent = 0;
  bit          quiet = 1'b0;
  bit          hold_off_req = 1'b0;

  quadrature_detent_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly short idle stretches, with the occasional long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [LOAD_W-1:0] random_load();
    if ($urandom_range(0, 3) == 0) return LOAD_MAX - LOAD_W'($urandom_range(0, 3));
    return LOAD_W'($urandom_range(0, 65535));
  endfunction

  // Offers one request and returns once it has been accepted. Valid is left
  // high when the next request follows at once.
  task automatic send_request(input logic [OPCODE_W-1:0] op,
                              input logic [PINS_W-1:0] pins,
                              input logic [LOAD_W-1:0] value);
    qdd_req_t    req;
    int unsigned gap;
    req.opcode     = op;
    req.pins       = pins;
    req.load_value = value;
    in_req_i   <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    tally.predict_detents(req);
    requests_sent++;
    gap = idle_length();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // One full detent in either direction, with occasional contact bounce
  // slipped in before a step.
  task automatic send_turn(input bit clockwise, input int unsigned bounce_pct);
    logic [PINS_W-1:0] steps [4];
    if (clockwise) begin
      steps[0] = PINS_HL;
      steps[1] = PINS_LL;
      steps[2] = PINS_LH;
    end else begin
      steps[0] = PINS_LH;
      steps[1] = PINS_LL;
      steps[2] = PINS_HL;
    end
    steps[3] = PINS_HH;
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 99) < bounce_pct)
        send_request(OP_SAMPLE, PINS_W'($urandom_range(0, 3)), random_load());
      send_request(OP_SAMPLE, steps[i], random_load());
    end
  endtask

  initial begin : receiver_pacing
    int unsigned run_left;
    bit          stalling;
    run_left = 0;
    stalling = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk_i);
        out_stall_i <= 1'b0;
        run_left = 0;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = ($urandom_range(0, 2) == 0);
          run_left = idle_length();
          if (run_left == 0) run_left = 1;
        end
        out_stall_i <= stalling;
        run_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tally.check_totals(out_rsp_o);
  end

  initial begin : stimulus
    int unsigned pick;
    bit          held;
    bit          drained;
    held    = 1'b0;
    drained = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: both turn directions with counter wrap, read and
    // clear, sync keeping the previous phase, unused opcodes and loads.
    quiet = 1'b1;
    send_request(OP_READ_CLEAR, PINS_HH, '0);
    send_request(OP_LOAD_CW, PINS_LL, LOAD_MAX);
    send_request(OP_LOAD_CCW, PINS_HH, LOAD_MAX);
    send_turn(1'b1, 0);
    send_turn(1'b0, 0);
    send_request(OP_READ_CLEAR, PINS_LL, LOAD_MAX);
    send_request(OP_READ_CLEAR, PINS_HL, '0);
    send_request(OP_SAMPLE, PINS_HL, '0);
    send_request(OP_SYNC, PINS_HL, LOAD_MAX);
    send_request(OP_SAMPLE, PINS_LL, '0);
    send_request(OP_SPARE_LO, PINS_LH, LOAD_MAX);
    send_request(OP_SPARE_HI, PINS_HH, '0);
    send_request(OP_LOAD_CW, PINS_LH, '0);
    send_request(OP_LOAD_CCW, PINS_HL, '0);
    send_request(OP_SYNC, PINS_HH, '0);
    quiet = 1'b0;

    while (requests_sent < TOTAL_REQUESTS) begin
      if (!held && requests_sent >= 700) begin
        // The receiver stops for a long stretch while requests keep coming.
        held = 1'b1;
        hold_off_req = 1'b1;
      end
      if (!drained && requests_sent >= 1400) begin
        drained = 1'b1;
        in_valid_i <= 1'b0;
        while (tally.outstanding() != 0) @(posedge clk_i);
      end
      quiet = (requests_sent >= 1000 && requests_sent < 1150);
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_turn(1'($urandom_range(0, 1)), 12);
      else if (pick < 65)
        send_request(OP_READ_CLEAR, PINS_W'($urandom_range(0, 3)), random_load());
      else if (pick < 70)
        send_request(OP_LOAD_CW, PINS_W'($urandom_range(0, 3)), random_load());
      else if (pick < 75)
        send_request(OP_LOAD_CCW, PINS_W'($urandom_range(0, 3)), random_load());
      else if (pick < 80)
        send_request(OP_SYNC, PINS_W'($urandom_range(0, 3)), random_load());
      else if (pick < 84)
        send_request(OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                     PINS_W'($urandom_range(0, 3)), random_load());
      else
        send_request(OP_SAMPLE, PINS_W'($urandom_range(0, 3)), random_load());
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (tally.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tally.mismatches == 0) begin
      $display("quadrature_detent_decoder verification clean");
    end else begin
      $display("quadrature_detent_decoder verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("quadrature_detent_decoder verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/qdd_pkg.sv
src/qdd_step.sv
src/quadrature_detent_decoder.sv
bench/quadrature_detent_decoder_tb.sv
